>>> rtl/core/dstf_pkg.sv
// dstf_pkg: shared types and constants for the decimal string to fixed-point parser.
// Holds the accumulator record and the fraction digit weight table.
// Depends on nothing; used by dstf_result and decimal_string_to_fixed_unit.
package dstf_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned INT_W  = 31;
  localparam int unsigned FRAC_W = 33;
  localparam int unsigned CNT_W  = 4;

  localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

  // Accumulated number, handed from the parser to the result stage
  typedef struct packed {
    logic              is_negative;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic              overflow;
  } acc_t;

  // round(2^32 * 10^-k); entry 0 is never selected
  function automatic logic [31:0] frac_weight(input logic [CNT_W-1:0] k);
    logic [31:0] w;
    case (k)
      4'd1:    w = 32'd429496730;
      4'd2:    w = 32'd42949673;
      4'd3:    w = 32'd4294967;
      4'd4:    w = 32'd429497;
      4'd5:    w = 32'd42950;
      4'd6:    w = 32'd4295;
      4'd7:    w = 32'd429;
      4'd8:    w = 32'd43;
      4'd9:    w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/dstf_result.sv
// dstf_result: turns the accumulated integer and fraction into a signed Q31.32 value.
// Clamps the magnitude to the positive range and applies the sign.
// Depends on dstf_pkg for acc_t.
module dstf_result
  import dstf_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  acc_t               acc,
  output logic signed [63:0] value,
  output logic               saturated
);

  localparam logic [31:0] FRAC_MASK = ~((32'd1 << (32 - FRAC_BITS)) - 32'd1);

  logic [31:0] upper;
  logic [63:0] mag;
  logic [63:0] mag_sat;
  logic        clamp;

  // Add the fraction carry bit into the integer half
  assign upper = {1'b0, acc.int_acc} + {31'd0, acc.frac_acc[32]};
  assign mag   = {upper, acc.frac_acc[31:0] & FRAC_MASK};

  // Clamp anything past 2^63-1, then apply the sign
  assign clamp     = mag[63];
  assign mag_sat   = clamp ? {1'b0, {63{1'b1}}} : mag;
  assign value     = acc.is_negative ? -$signed(mag_sat) : $signed(mag_sat);
  assign saturated = acc.overflow | clamp;

endmodule

>>> rtl/core/decimal_string_to_fixed_unit.sv
// decimal_string_to_fixed_unit: top level of the ASCII decimal to Q31.32 parser.
// Depends on dstf_pkg and dstf_result.
//
// Usage:
//   The input channel (in_valid, in_stall, in_ch) carries one ASCII character
//   per request. Leading spaces are skipped, one minus sign may follow, then
//   integer digits, a dot and fraction digits; any other character stops the
//   parse until the terminator. Character 0 ends the string and produces one
//   request on the result channel (out_valid, out_stall, out_value,
//   out_saturated); other characters produce none.
//   Throughput: one character per cycle unless a terminator is held back by a
//   stalled result; the rate is set by the digit update (multiply by ten and add,
//   or weighted fraction add) feeding back on the accumulators. The terminator
//   passes through the input register and then the result register, and a
//   stalled result ahead of it holds it in the input register.
//   When the receiver stalls, the result holds; characters keep flowing while
//   a terminator is waiting, and only a second terminator is held back.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the leading-space phase; every terminator resets the parser too.
module decimal_string_to_fixed_unit
  import dstf_pkg::*;
#(
  parameter int FRAC_DIGITS = 10,
  parameter int FRAC_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_saturated
);

  localparam logic [CNT_W-1:0] FRAC_LIMIT = CNT_W'(FRAC_DIGITS);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_STOP
  } phase_t;

  // Input register
  logic       in_valid_r;
  logic [7:0] ch_r;

  // Parser state
  phase_t           phase_r, phase_nxt;
  acc_t             acc_r, acc_nxt;
  logic [CNT_W-1:0] frac_count_r, frac_count_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_value_r;
  logic               out_saturated_r;

  logic               adv;
  logic               is_term;
  logic signed [63:0] res_value;
  logic               res_saturated;

  // Body-character helpers
  logic             is_digit;
  logic [3:0]       digit;
  logic [34:0]      int_sum;
  logic [CNT_W-1:0] cnt_inc;
  logic [35:0]      frac_prod;
  logic [FRAC_W-1:0] frac_sum;

  assign is_term  = (ch_r == CH_NUL);
  // Advance the held character unless a terminator meets a blocked result
  assign adv      = in_valid_r & (~is_term | ~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~adv;

  assign is_digit  = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign digit     = 4'(ch_r - CH_ZERO);
  assign int_sum   = ({4'd0, acc_r.int_acc} << 3) + ({4'd0, acc_r.int_acc} << 1)
                   + {31'd0, digit};
  assign cnt_inc   = frac_count_r + CNT_W'(1);
  assign frac_prod = {32'd0, digit} * {4'd0, frac_weight(cnt_inc)};
  assign frac_sum  = acc_r.frac_acc + frac_prod[FRAC_W-1:0];

  // Build the result from the state as it stands before the terminator
  dstf_result #(
    .FRAC_BITS(FRAC_BITS)
  ) u_result (
    .acc      (acc_r),
    .value    (res_value),
    .saturated(res_saturated)
  );

  // Next parser state
  always_comb begin
    logic body;
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    frac_count_nxt = frac_count_r;
    body           = 1'b0;
    if (adv) begin
      if (is_term) begin
        phase_nxt      = PH_LEAD;
        acc_nxt        = '0;
        frac_count_nxt = '0;
      end else if (phase_r == PH_LEAD) begin
        if (ch_r != CH_SPACE) begin
          phase_nxt = PH_INT;
          if (ch_r == CH_MINUS) begin
            acc_nxt.is_negative = 1'b1;
          end else begin
            body = 1'b1;
          end
        end
      end else if (phase_r != PH_STOP) begin
        body = 1'b1;
      end
    end
    if (body) begin
      if (ch_r == CH_DOT) begin
        phase_nxt = PH_FRAC;
      end else if (is_digit) begin
        if (phase_r == PH_FRAC) begin
          if (frac_count_r < FRAC_LIMIT) begin
            frac_count_nxt   = cnt_inc;
            acc_nxt.frac_acc = frac_sum;
          end
        end else begin
          phase_nxt = PH_INT;
          if (int_sum > {4'd0, INT_MAX}) begin
            acc_nxt.int_acc  = INT_MAX;
            acc_nxt.overflow = 1'b1;
          end else begin
            acc_nxt.int_acc = int_sum[INT_W-1:0];
          end
        end
      end else begin
        phase_nxt = PH_STOP;
      end
    end
  end

  // Drop the result once taken, load a new one on a terminator
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (adv && is_term) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_LEAD;
      acc_r        <= '0;
      frac_count_r <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      frac_count_r <= frac_count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ch_r <= in_ch;
    end
    if (adv && is_term) begin
      out_value_r     <= res_value;
      out_saturated_r <= res_saturated;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_saturated_r;

endmodule
